// ===== hw/rtl/aesx_pkg.sv =====
// ----------------------------------------------------------------------------
// aesx_pkg
// Shared constants and helper functions for the AES S-box block.
// ----------------------------------------------------------------------------
package aesx_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LUT_DEPTH  = 256;
    localparam int unsigned LUT_ADDR_W = 9;   // direction bit plus byte

    localparam logic CMD_FWD = 1'b1;
    localparam logic CMD_INV = 1'b0;

    localparam logic [BYTE_W-1:0] AFF_FWD_C = 8'h63;
    localparam logic [BYTE_W-1:0] AFF_INV_C = 8'h05;

    function automatic logic [BYTE_W-1:0] rotl(input logic [BYTE_W-1:0] v,
                                               input int unsigned n);
        logic [2*BYTE_W-1:0] w;
        w = {v, v} << n;
        return w[2*BYTE_W-1 -: BYTE_W];
    endfunction

    function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] x,
                                                 input logic [BYTE_W-1:0] y);
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] a;
        acc = '0;
        a   = x;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (y[i])
                acc = acc ^ a;
            a = a[BYTE_W-1] ? ((a << 1) ^ 8'h1B) : (a << 1);
        end
        return acc;
    endfunction

    // x^254; zero maps to zero. Elaboration-time only (table build).
    function automatic logic [BYTE_W-1:0] gf_inv(input logic [BYTE_W-1:0] x);
        logic [BYTE_W-1:0] r;
        logic [BYTE_W-1:0] b;
        r = 8'h01;
        b = x;
        for (int i = 1; i < BYTE_W; i++)
        begin
            b = gf_mul(b, b);
            r = gf_mul(r, b);
        end
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] affine_fwd(input logic [BYTE_W-1:0] a);
        return a ^ rotl(a, 1) ^ rotl(a, 2) ^ rotl(a, 3) ^ rotl(a, 4) ^ AFF_FWD_C;
    endfunction

    function automatic logic [BYTE_W-1:0] affine_inv(input logic [BYTE_W-1:0] b);
        return rotl(b, 1) ^ rotl(b, 3) ^ rotl(b, 6) ^ AFF_INV_C;
    endfunction

    // Table entry: address is {dir, byte}
    function automatic logic [BYTE_W-1:0] sbox_entry(input logic [LUT_ADDR_W-1:0] addr);
        logic [BYTE_W-1:0] v;
        v = addr[BYTE_W-1:0];
        if (addr[BYTE_W] == CMD_FWD)
            return affine_fwd(gf_inv(v));
        else
            return gf_inv(affine_inv(v));
    endfunction

endpackage

// ===== hw/rtl/aes_sbox_fwd_inv.sv =====
// ----------------------------------------------------------------------------
// aes_sbox_fwd_inv
// AES forward / inverse S-box, one byte per request, valid/ready streaming.
// ----------------------------------------------------------------------------
// One request per clock unless the output stalls. The substitution is held
// in a 512-entry synchronous ROM (forward table in the upper half, inverse
// in the lower), addressed by {cmd, data_in}. A request is accepted whenever
// the output register is empty or being drained, so throughput is one byte
// per cycle, and data_out is valid in the cycle after acceptance, through the
// single registered ROM read. The ROM contents are constant, so no write
// path, forwarding or clearing pass exists; reset only clears out_valid.
module aes_sbox_fwd_inv
    import aesx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cmd,
    input  logic [BYTE_W-1:0] data_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] data_out
);

    // Constant table, built at elaboration.
    logic [BYTE_W-1:0] rom [LUT_DEPTH*2];
    always_comb
    begin
        for (int i = 0; i < LUT_DEPTH*2; i++)
            rom[i] = sbox_entry(LUT_ADDR_W'(i));
    end

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              accept;

    // Output register can refill in the same cycle it drains.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Registered ROM read.
    always_ff @(posedge clk)
    begin
        if (accept)
            data_reg <= rom[{cmd, data_in}];
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_out))
        else $error("result dropped while stalled");
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted request produced no result");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");
    a_fwd0: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd == CMD_FWD && data_in == '0 |=> data_out == AFF_FWD_C)
        else $error("forward S-box of zero wrong");

endmodule
